>>> hw/rtl/fcc_pkg.sv
// Shared types, constants and tables of the four-function calculator core.
package fcc_pkg;

  localparam int unsigned DATA_W = 64;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned ITER_W = 6;
  localparam int unsigned DIGIT_W = 4;
  localparam int unsigned OPCODE_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned PEND_W = 3;
  localparam int unsigned POW_IDX_W = 5;

  localparam int unsigned MAX_DISPLAY_CHARS_DEF = 15;

  localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DATA_W - 1);
  localparam logic [ITER_W-1:0] CNT_FIRST = ITER_W'(1);
  localparam logic [ITER_W-1:0] CNT_LAST = ITER_W'(19);
  localparam logic [DIGIT_W-1:0] DIGIT_MAX = DIGIT_W'(9);

  localparam logic [PEND_W-1:0] OP_NONE = 3'd0;
  localparam logic [PEND_W-1:0] OP_ADD = 3'd1;
  localparam logic [PEND_W-1:0] OP_SUB = 3'd2;
  localparam logic [PEND_W-1:0] OP_MUL = 3'd3;
  localparam logic [PEND_W-1:0] OP_DIV = 3'd4;

  typedef enum logic [MODE_W-1:0] {
    MODE_DIGIT = 2'd0,
    MODE_OPERATOR = 2'd1,
    MODE_EQUALS = 2'd2,
    MODE_CLEAR = 2'd3
  } fcc_mode_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_DIG_MUL,
    ST_DIG_ADD,
    ST_EQ_START,
    ST_MUL,
    ST_DIV,
    ST_DIV_FIN,
    ST_COMMIT,
    ST_COUNT,
    ST_OP_LATCH,
    ST_RESPOND
  } fcc_state_e;

  typedef enum logic [3:0] {
    CMD_NONE,
    CMD_CLEAR,
    CMD_DIG_START,
    CMD_DIG_MUL,
    CMD_DIG_ADD,
    CMD_EQ_INIT,
    CMD_MUL_STEP,
    CMD_DIV_STEP,
    CMD_DIV_FIN,
    CMD_COMMIT,
    CMD_CNT_STEP,
    CMD_OP_LATCH
  } fcc_cmd_e;

  typedef struct packed {
    fcc_cmd_e op;
    logic capture;
    logic emit;
  } fcc_cmd_t;

  typedef struct packed {
    fcc_mode_e mode;
    logic digit_ok;
    logic awaiting;
    logic [PEND_W-1:0] pend_op;
    logic disp_full;
    logic step_last;
    logic count_last;
  } fcc_stat_t;

  // Powers of ten used to count the decimal digits of a magnitude.
  function automatic logic [DATA_W-1:0] pow10(input logic [POW_IDX_W-1:0] idx);
    logic [DATA_W-1:0] p;
    case (idx)
      5'd0: p = 64'd1;
      5'd1: p = 64'd10;
      5'd2: p = 64'd100;
      5'd3: p = 64'd1000;
      5'd4: p = 64'd10000;
      5'd5: p = 64'd100000;
      5'd6: p = 64'd1000000;
      5'd7: p = 64'd10000000;
      5'd8: p = 64'd100000000;
      5'd9: p = 64'd1000000000;
      5'd10: p = 64'd10000000000;
      5'd11: p = 64'd100000000000;
      5'd12: p = 64'd1000000000000;
      5'd13: p = 64'd10000000000000;
      5'd14: p = 64'd100000000000000;
      5'd15: p = 64'd1000000000000000;
      5'd16: p = 64'd10000000000000000;
      5'd17: p = 64'd100000000000000000;
      5'd18: p = 64'd1000000000000000000;
      5'd19: p = 64'd10000000000000000000;
      default: p = '1;
    endcase
    return p;
  endfunction

endpackage

>>> hw/rtl/fcc_intf.sv
// Handshake interfaces for the key event and display result channels.
interface fcc_key_if;
  import fcc_pkg::*;

  logic valid;
  logic ready;
  logic [MODE_W-1:0] mode;
  logic [DIGIT_W-1:0] digit_value;
  logic [OPCODE_W-1:0] operator_code;

  modport source (output valid, output mode, output digit_value, output operator_code,
                  input ready);
  modport sink (input valid, input mode, input digit_value, input operator_code,
                output ready);
endinterface

interface fcc_disp_if;
  import fcc_pkg::*;

  logic valid;
  logic ready;
  logic signed [DATA_W-1:0] display_value;
  logic [PEND_W-1:0] pending_operator;
  logic awaiting_number;

  modport source (output valid, output display_value, output pending_operator,
                  output awaiting_number, input ready);
  modport sink (input valid, input display_value, input pending_operator,
                input awaiting_number, output ready);
endinterface

>>> hw/rtl/fcc_datapath.sv
// Calculator datapath: display state, shift-add multiplier, restoring divider, digit counter.
module fcc_datapath #(
  parameter int unsigned MaxDisplayChars = fcc_pkg::MAX_DISPLAY_CHARS_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  fcc_pkg::fcc_cmd_t                   cmd_i,
  output fcc_pkg::fcc_stat_t                  stat_o,
  input  logic [fcc_pkg::MODE_W-1:0]          key_mode_i,
  input  logic [fcc_pkg::DIGIT_W-1:0]         key_digit_i,
  input  logic [fcc_pkg::OPCODE_W-1:0]        key_opcode_i,
  output logic signed [fcc_pkg::DATA_W-1:0]   disp_value_o,
  output logic [fcc_pkg::PEND_W-1:0]          disp_op_o,
  output logic                                disp_await_o
);
  import fcc_pkg::*;

  logic [DATA_W-1:0] shown_q, shown_d;
  logic [DATA_W-1:0] acc_q, acc_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [PEND_W-1:0] op_q, op_d;
  logic snn_q, snn_d;

  fcc_mode_e mode_q, mode_d;
  logic [DIGIT_W-1:0] digit_q, digit_d;
  logic [OPCODE_W-1:0] opcode_q, opcode_d;

  logic [DATA_W-1:0] a_q, a_d;
  logic [DATA_W-1:0] b_q, b_d;
  logic [DATA_W-1:0] res_q, res_d;
  logic [DATA_W-1:0] rem_q, rem_d;
  logic neg_q, neg_d;
  logic dz_q, dz_d;
  logic [ITER_W-1:0] iter_q, iter_d;

  logic [DATA_W-1:0] out_value_q, out_value_d;
  logic [PEND_W-1:0] out_op_q, out_op_d;
  logic out_await_q, out_await_d;

  logic [DATA_W:0] trial;
  logic [DATA_W:0] trial_diff;
  logic trial_ge;
  logic [DATA_W-1:0] digit_ext;
  logic [DATA_W-1:0] acc_mag;
  logic [DATA_W-1:0] shown_mag;
  logic [DATA_W-1:0] res_mag;

  always_comb begin
    digit_ext = {{(DATA_W - DIGIT_W){1'b0}}, digit_q};
    acc_mag = acc_q[DATA_W-1] ? (~acc_q + 1'b1) : acc_q;
    shown_mag = shown_q[DATA_W-1] ? (~shown_q + 1'b1) : shown_q;
    res_mag = res_q[DATA_W-1] ? (~res_q + 1'b1) : res_q;
    trial = {rem_q, a_q[DATA_W-1]};
    trial_diff = trial - {1'b0, b_q};
    trial_ge = !trial_diff[DATA_W];

    shown_d = shown_q;
    acc_d = acc_q;
    cnt_d = cnt_q;
    op_d = op_q;
    snn_d = snn_q;
    mode_d = mode_q;
    digit_d = digit_q;
    opcode_d = opcode_q;
    a_d = a_q;
    b_d = b_q;
    res_d = res_q;
    rem_d = rem_q;
    neg_d = neg_q;
    dz_d = dz_q;
    iter_d = iter_q;
    out_value_d = out_value_q;
    out_op_d = out_op_q;
    out_await_d = out_await_q;

    if (cmd_i.capture) begin
      mode_d = fcc_mode_e'(key_mode_i);
      digit_d = key_digit_i;
      opcode_d = key_opcode_i;
    end

    if (cmd_i.emit) begin
      out_value_d = shown_q;
      out_op_d = op_q;
      out_await_d = snn_q;
    end

    case (cmd_i.op)
      CMD_CLEAR: begin
        shown_d = '0;
        cnt_d = CNT_W'(1);
        acc_d = '0;
        op_d = OP_NONE;
        snn_d = 1'b1;
      end
      CMD_DIG_START: begin
        shown_d = digit_ext;
        cnt_d = CNT_W'(1);
        snn_d = 1'b0;
      end
      CMD_DIG_MUL: begin
        res_d = {shown_q[DATA_W-4:0], 3'b000} + {shown_q[DATA_W-2:0], 1'b0};
      end
      CMD_DIG_ADD: begin
        shown_d = shown_q[DATA_W-1] ? (res_q - digit_ext) : (res_q + digit_ext);
        cnt_d = cnt_q + 1'b1;
      end
      CMD_EQ_INIT: begin
        iter_d = '0;
        rem_d = '0;
        neg_d = acc_q[DATA_W-1] ^ shown_q[DATA_W-1];
        dz_d = (shown_q == '0);
        case (op_q)
          OP_ADD: res_d = acc_q + shown_q;
          OP_SUB: res_d = acc_q - shown_q;
          OP_MUL: begin
            a_d = acc_q;
            b_d = shown_q;
            res_d = '0;
          end
          OP_DIV: begin
            a_d = acc_mag;
            b_d = shown_mag;
          end
          default: res_d = '0;
        endcase
      end
      CMD_MUL_STEP: begin
        if (b_q[0]) begin
          res_d = res_q + a_q;
        end
        a_d = {a_q[DATA_W-2:0], 1'b0};
        b_d = {1'b0, b_q[DATA_W-1:1]};
        iter_d = iter_q + 1'b1;
      end
      CMD_DIV_STEP: begin
        rem_d = trial_ge ? trial_diff[DATA_W-1:0] : trial[DATA_W-1:0];
        a_d = {a_q[DATA_W-2:0], trial_ge};
        iter_d = iter_q + 1'b1;
      end
      CMD_DIV_FIN: begin
        if (dz_q) begin
          res_d = '0;
        end else if (neg_q) begin
          res_d = ~a_q + 1'b1;
        end else begin
          res_d = a_q;
        end
      end
      CMD_COMMIT: begin
        shown_d = res_q;
        acc_d = res_q;
        op_d = OP_NONE;
        snn_d = 1'b1;
        cnt_d = res_q[DATA_W-1] ? CNT_W'(2) : CNT_W'(1);
        a_d = res_mag;
        iter_d = CNT_FIRST;
      end
      CMD_CNT_STEP: begin
        if (a_q >= pow10(iter_q[POW_IDX_W-1:0])) begin
          cnt_d = cnt_q + 1'b1;
        end
        iter_d = iter_q + 1'b1;
      end
      CMD_OP_LATCH: begin
        acc_d = shown_q;
        op_d = {1'b0, opcode_q} + OP_ADD;
        snn_d = 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shown_q <= '0;
      acc_q <= '0;
      cnt_q <= CNT_W'(1);
      op_q <= OP_NONE;
      snn_q <= 1'b1;
      mode_q <= MODE_CLEAR;
    end else begin
      shown_q <= shown_d;
      acc_q <= acc_d;
      cnt_q <= cnt_d;
      op_q <= op_d;
      snn_q <= snn_d;
      mode_q <= mode_d;
    end
  end

  always_ff @(posedge clk_i) begin
    digit_q <= digit_d;
    opcode_q <= opcode_d;
    a_q <= a_d;
    b_q <= b_d;
    res_q <= res_d;
    rem_q <= rem_d;
    neg_q <= neg_d;
    dz_q <= dz_d;
    iter_q <= iter_d;
    out_value_q <= out_value_d;
    out_op_q <= out_op_d;
    out_await_q <= out_await_d;
  end

  always_comb begin
    stat_o.mode = mode_q;
    stat_o.digit_ok = (digit_q <= DIGIT_MAX);
    stat_o.awaiting = snn_q;
    stat_o.pend_op = op_q;
    stat_o.disp_full = !(cnt_q < CNT_W'(MaxDisplayChars));
    stat_o.step_last = (iter_q == ITER_LAST);
    stat_o.count_last = (iter_q == CNT_LAST);
  end

  assign disp_value_o = signed'(out_value_q);
  assign disp_op_o = out_op_q;
  assign disp_await_o = out_await_q;

endmodule

>>> hw/rtl/fcc_ctrl.sv
// Calculator controller: sequences each key event through the datapath and owns the handshakes.
module fcc_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               key_valid_i,
  output logic               key_ready_o,
  output logic               disp_valid_o,
  input  logic               disp_ready_i,
  input  fcc_pkg::fcc_stat_t stat_i,
  output fcc_pkg::fcc_cmd_t  cmd_o
);
  import fcc_pkg::*;

  fcc_state_e state_q, state_d;
  logic out_valid_q, out_valid_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o.op = CMD_NONE;
    cmd_o.capture = 1'b0;
    cmd_o.emit = 1'b0;
    key_ready_o = (state_q == ST_IDLE);

    case (state_q)
      ST_IDLE: begin
        if (key_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d = ST_DECODE;
        end
      end
      ST_DECODE: begin
        case (stat_i.mode)
          MODE_DIGIT: begin
            if (!stat_i.digit_ok) begin
              state_d = ST_RESPOND;
            end else if (stat_i.awaiting) begin
              cmd_o.op = CMD_DIG_START;
              state_d = ST_RESPOND;
            end else if (!stat_i.disp_full) begin
              state_d = ST_DIG_MUL;
            end else begin
              state_d = ST_RESPOND;
            end
          end
          MODE_OPERATOR: begin
            if (stat_i.pend_op != OP_NONE && !stat_i.awaiting) begin
              state_d = ST_EQ_START;
            end else begin
              state_d = ST_OP_LATCH;
            end
          end
          MODE_EQUALS: begin
            if (stat_i.pend_op != OP_NONE) begin
              state_d = ST_EQ_START;
            end else begin
              state_d = ST_RESPOND;
            end
          end
          default: begin
            cmd_o.op = CMD_CLEAR;
            state_d = ST_RESPOND;
          end
        endcase
      end
      ST_DIG_MUL: begin
        cmd_o.op = CMD_DIG_MUL;
        state_d = ST_DIG_ADD;
      end
      ST_DIG_ADD: begin
        cmd_o.op = CMD_DIG_ADD;
        state_d = ST_RESPOND;
      end
      ST_EQ_START: begin
        cmd_o.op = CMD_EQ_INIT;
        if (stat_i.pend_op == OP_MUL) begin
          state_d = ST_MUL;
        end else if (stat_i.pend_op == OP_DIV) begin
          state_d = ST_DIV;
        end else begin
          state_d = ST_COMMIT;
        end
      end
      ST_MUL: begin
        cmd_o.op = CMD_MUL_STEP;
        if (stat_i.step_last) begin
          state_d = ST_COMMIT;
        end
      end
      ST_DIV: begin
        cmd_o.op = CMD_DIV_STEP;
        if (stat_i.step_last) begin
          state_d = ST_DIV_FIN;
        end
      end
      ST_DIV_FIN: begin
        cmd_o.op = CMD_DIV_FIN;
        state_d = ST_COMMIT;
      end
      ST_COMMIT: begin
        cmd_o.op = CMD_COMMIT;
        state_d = ST_COUNT;
      end
      ST_COUNT: begin
        cmd_o.op = CMD_CNT_STEP;
        if (stat_i.count_last) begin
          state_d = (stat_i.mode == MODE_OPERATOR) ? ST_OP_LATCH : ST_RESPOND;
        end
      end
      ST_OP_LATCH: begin
        cmd_o.op = CMD_OP_LATCH;
        state_d = ST_RESPOND;
      end
      ST_RESPOND: begin
        if (!out_valid_q || disp_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (disp_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  assign disp_valid_o = out_valid_q;

endmodule

>>> hw/rtl/four_function_calculator_core.sv
// Top level of the four-function calculator core.
// Key events enter on key_i: a digit, an operator, equals or clear. Every event
// yields exactly one beat on disp_o with the displayed value, the pending operator
// and the flag that says the next digit starts a new number.
// A beat is taken when valid and ready are both high. One event is worked at a
// time; key_i.ready is high only while the controller waits for an event.
// An accepted event passes DECODE and RESPOND; a digit that starts a number, clear,
// or an ignored key needs nothing more, an appended digit adds DIG_MUL and DIG_ADD
// and an operator with nothing to resolve adds OP_LATCH. Equals runs EQ_START, then
// MUL (one shift-add step a cycle) or DIV and DIV_FIN (one restoring step a cycle)
// for multiply or divide, then COMMIT and a 19-step decimal digit count; an operator
// that resolves a pending operation then adds OP_LATCH. The controller waits for
// the next event again in the same cycle that the result appears in the output register.
// Reset clears the display to zero, the accumulator to zero, the pending operator
// to none and sets the new-number flag, as a clear key does.
// While disp_o is stalled the finished result waits in the output register; the
// block still accepts and works the next event and holds its result until the
// output register frees up.
module four_function_calculator_core #(
  parameter int unsigned MaxDisplayChars = fcc_pkg::MAX_DISPLAY_CHARS_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  fcc_key_if.sink    key_i,
  fcc_disp_if.source disp_o
);
  import fcc_pkg::*;

  fcc_cmd_t cmd;
  fcc_stat_t stat;

  fcc_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .key_valid_i  (key_i.valid),
    .key_ready_o  (key_i.ready),
    .disp_valid_o (disp_o.valid),
    .disp_ready_i (disp_o.ready),
    .stat_i       (stat),
    .cmd_o        (cmd)
  );

  fcc_datapath #(
    .MaxDisplayChars (MaxDisplayChars)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .key_mode_i   (key_i.mode),
    .key_digit_i  (key_i.digit_value),
    .key_opcode_i (key_i.operator_code),
    .disp_value_o (disp_o.display_value),
    .disp_op_o    (disp_o.pending_operator),
    .disp_await_o (disp_o.awaiting_number)
  );

  // A new event is never taken in the cycle right after one was accepted.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_i.valid && key_i.ready |=> !key_i.ready)
    else $error("key accepted while the previous event is still in work");

  // The result channel turns valid only after the controller loaded a result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(disp_o.valid) |-> $past(cmd.emit))
    else $error("result valid without a loaded result");

  // A reported pending operator is always a defined code.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    disp_o.valid |-> disp_o.pending_operator <= OP_DIV)
    else $error("undefined pending operator on the result channel");

  // An event capture is followed by decode, never by another capture or an emit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.capture |=> !cmd.capture && !cmd.emit)
    else $error("event capture not followed by decode");

endmodule
